[src/bdsd_pkg.sv]
// Shared types and constants for the bounded deque with search and delete.
// Holds the mode, result status and controller state codes and the
// controller/datapath command and status structs. No dependencies.
package bdsd_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_DUMP_FWD   = 3'd2,
    MODE_DUMP_BWD   = 3'd3,
    MODE_SEARCH     = 3'd4,
    MODE_DELETE     = 3'd5,
    MODE_COUNT      = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RESULT,
    S_DUMP_RD,
    S_DUMP_EMIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_NEXT,
    ADDR_DUMP,
    ADDR_BACK
  } addr_sel_t;

  typedef struct packed {
    logic      load_in;
    logic      push;
    logic      clear;
    logic      idx_clear;
    logic      idx_inc;
    logic      dec_count;
    logic      rd_en;
    logic      wr_shift;
    addr_sel_t addr_sel;
    logic      emit;
    logic      emit_elem;
    logic      emit_last;
    status_t   emit_status;
    logic      emit_found;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  full;
    logic  idx_last;
    logic  match;
    logic  out_free;
  } sts_t;

endpackage

[src/bdsd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bdsd_ctrl.sv]
// Controller state machine for the bounded deque: sequences each operation
// and drives the datapath through bdsd_pkg::cmd_t. Depends on bdsd_pkg.
module bdsd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bdsd_pkg::sts_t sts,
  output bdsd_pkg::cmd_t cmd
);

  bdsd_pkg::state_t  state, state_next;
  bdsd_pkg::status_t pend_status, pend_status_next;
  logic              pend_found, pend_found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bdsd_pkg::S_IDLE;
      pend_status <= bdsd_pkg::STAT_OK;
      pend_found  <= 1'b0;
    end else begin
      state       <= state_next;
      pend_status <= pend_status_next;
      pend_found  <= pend_found_next;
    end
  end

  always_comb begin
    state_next       = state;
    pend_status_next = pend_status;
    pend_found_next  = pend_found;
    cmd              = '0;
    in_stall         = 1'b1;
    unique case (state)
      bdsd_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = bdsd_pkg::S_DECODE;
        end
      end
      bdsd_pkg::S_DECODE: begin
        pend_status_next = bdsd_pkg::STAT_OK;
        pend_found_next  = 1'b0;
        state_next       = bdsd_pkg::S_RESULT;
        unique case (sts.mode)
          bdsd_pkg::MODE_PUSH_FRONT, bdsd_pkg::MODE_PUSH_BACK: begin
            if (sts.full) begin
              pend_status_next = bdsd_pkg::STAT_FULL;
            end else begin
              cmd.push     = 1'b1;
              cmd.addr_sel = bdsd_pkg::ADDR_BACK;
            end
          end
          bdsd_pkg::MODE_DUMP_FWD, bdsd_pkg::MODE_DUMP_BWD: begin
            if (sts.empty) begin
              pend_status_next = bdsd_pkg::STAT_EMPTY;
            end else begin
              cmd.idx_clear = 1'b1;
              state_next    = bdsd_pkg::S_DUMP_RD;
            end
          end
          bdsd_pkg::MODE_SEARCH, bdsd_pkg::MODE_DELETE: begin
            if (sts.empty) begin
              pend_status_next = bdsd_pkg::STAT_EMPTY;
            end else begin
              cmd.idx_clear = 1'b1;
              state_next    = bdsd_pkg::S_SCAN_RD;
            end
          end
          bdsd_pkg::MODE_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      bdsd_pkg::S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = pend_status;
          cmd.emit_found  = pend_found;
          state_next      = bdsd_pkg::S_IDLE;
        end
      end
      bdsd_pkg::S_DUMP_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = bdsd_pkg::ADDR_DUMP;
        state_next   = bdsd_pkg::S_DUMP_EMIT;
      end
      bdsd_pkg::S_DUMP_EMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_elem = 1'b1;
          cmd.emit_last = sts.idx_last;
          cmd.idx_inc   = 1'b1;
          state_next    = sts.idx_last ? bdsd_pkg::S_IDLE : bdsd_pkg::S_DUMP_RD;
        end
      end
      bdsd_pkg::S_SCAN_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = bdsd_pkg::ADDR_IDX;
        state_next   = bdsd_pkg::S_SCAN_CHK;
      end
      bdsd_pkg::S_SCAN_CHK: begin
        if (sts.match) begin
          if (sts.mode == bdsd_pkg::MODE_SEARCH) begin
            pend_status_next = bdsd_pkg::STAT_OK;
            pend_found_next  = 1'b1;
            state_next       = bdsd_pkg::S_RESULT;
          end else begin
            state_next = bdsd_pkg::S_SHIFT_RD;
          end
        end else if (sts.idx_last) begin
          pend_status_next = bdsd_pkg::STAT_NOT_FOUND;
          pend_found_next  = 1'b0;
          state_next       = bdsd_pkg::S_RESULT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = bdsd_pkg::S_SCAN_RD;
        end
      end
      bdsd_pkg::S_SHIFT_RD: begin
        if (sts.idx_last) begin
          cmd.dec_count    = 1'b1;
          pend_status_next = bdsd_pkg::STAT_OK;
          pend_found_next  = 1'b0;
          state_next       = bdsd_pkg::S_RESULT;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_sel = bdsd_pkg::ADDR_NEXT;
          state_next   = bdsd_pkg::S_SHIFT_WR;
        end
      end
      bdsd_pkg::S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.addr_sel = bdsd_pkg::ADDR_IDX;
        cmd.idx_inc  = 1'b1;
        state_next   = bdsd_pkg::S_SHIFT_RD;
      end
      default: begin
        state_next = bdsd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[src/bdsd_dp.sv]
// Datapath for the bounded deque: ring front pointer, element count, walk index,
// element RAM and the result register. Depends on bdsd_pkg and bdsd_ram.
module bdsd_dp #(
  parameter int CAPACITY   = bdsd_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdsd_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bdsd_pkg::cmd_t      cmd,
  output bdsd_pkg::sts_t      sts,
  input  logic [2:0]          mode,
  input  logic signed [31:0]  value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic                found,
  output logic signed [31:0]  element_value,
  output logic [5:0]          element_count,
  output logic                last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = IDX_W + 1;

  bdsd_pkg::mode_t       mode_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [IDX_W-1:0]      front;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;

  logic [CNT_W-1:0]      off;
  logic [POS_W-1:0]      pos_sum;
  logic [IDX_W-1:0]      pos;
  logic [IDX_W-1:0]      front_dec;
  logic [IDX_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  we;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  empty;
  logic                  out_free;

  assign empty    = (count == '0);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.addr_sel)
      bdsd_pkg::ADDR_IDX:  off = idx;
      bdsd_pkg::ADDR_NEXT: off = idx + CNT_W'(1);
      bdsd_pkg::ADDR_DUMP: off = (mode_r == bdsd_pkg::MODE_DUMP_BWD) ?
                                 count - CNT_W'(1) - idx : idx;
      default:             off = count;
    endcase
    pos_sum = POS_W'(front) + POS_W'(off);
    if (pos_sum >= POS_W'(CAPACITY)) begin
      pos_sum = pos_sum - POS_W'(CAPACITY);
    end
    pos = pos_sum[IDX_W-1:0];
  end

  assign front_dec = empty ? '0 :
                     (front == '0) ? IDX_W'(CAPACITY - 1) : front - IDX_W'(1);

  always_comb begin
    we    = cmd.push || cmd.wr_shift;
    wdata = cmd.push ? value_r : rdata;
    if (cmd.push && mode_r == bdsd_pkg::MODE_PUSH_FRONT) begin
      waddr = front_dec;
    end else if (cmd.push && empty) begin
      waddr = '0;
    end else begin
      waddr = pos;
    end
  end

  bdsd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (pos),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r  <= bdsd_pkg::mode_t'(mode);
      value_r <= DATA_WIDTH'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.clear) begin
        front <= '0;
        count <= '0;
      end else if (cmd.push) begin
        front <= (mode_r == bdsd_pkg::MODE_PUSH_FRONT) ? front_dec :
                 (empty ? '0 : front);
        count <= count + CNT_W'(1);
      end else if (cmd.dec_count) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status        <= cmd.emit_status;
      found         <= cmd.emit_found;
      element_value <= cmd.emit_elem ? 32'($signed(rdata)) : '0;
      element_count <= 6'(count);
      last          <= cmd.emit_last;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.empty    = empty;
  assign sts.full     = (count >= CNT_W'(CAPACITY));
  assign sts.idx_last = ((idx + CNT_W'(1)) == count);
  assign sts.match    = (rdata == value_r);
  assign sts.out_free = out_free;

endmodule

[src/bounded_deque_search_delete_top.sv]
// Bounded deque of signed values with search and order-keeping delete.
// Input beat: mode + value on in_valid/in_stall. Output beat: status, found,
// element_value, element_count, last on out_valid/out_stall.
// One item is worked at a time; in_stall stays high until the item's last
// result beat is loaded into the output register.
// Steps per item:
//   push, count, clear, empty cases: decode, then the result beat.
//   search: one registered RAM read and a compare per element visited.
//   delete: search walk, then a read and a write per element moved to close the
//   gap, then the count drops and the result beat follows.
//   dump: per element, a registered RAM read and then its beat.
// The single element RAM port pair makes every walk step a registered read, then its use.
// An insert into a full list gives status full and leaves the list alone.
// Reset (rst, synchronous) empties the list and drops any pending beat; no
// clearing pass is run, stored values are only read while live.
// A stalled output holds its beat; a dump walk or result step waits until the beat is taken.
// Depends on bdsd_pkg, bdsd_ctrl, bdsd_dp, bdsd_ram.
module bounded_deque_search_delete_top #(
  parameter int CAPACITY   = bdsd_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdsd_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               found,
  output logic signed [31:0] element_value,
  output logic [5:0]         element_count,
  output logic               last
);

  bdsd_pkg::cmd_t cmd;
  bdsd_pkg::sts_t sts;

  bdsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bdsd_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (mode),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .found         (found),
    .element_value (element_value),
    .element_count (element_count),
    .last          (last)
  );

endmodule

[tb/bounded_deque_search_delete_top_test.sv]
// Self-checking testbench for bounded_deque_search_delete_top: a directed table, then random
// phases of fill, drain and mixed traffic, with random idle and stall bursts on both channels.
// Depends on bdsd_pkg and the top module; every output beat is checked against a shadow list.
module bounded_deque_search_delete_top_test;
  import bdsd_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int RAND_ITEMS = 240;
  localparam int CALM_ITEMS = 30;
  localparam int TAIL_WAIT  = 140;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic signed [31:0] elem;
    logic [5:0]         cnt;
    logic               last;
  } beat_t;

  typedef struct packed {
    mode_t              m;
    logic signed [31:0] v;
    logic               typed;
    status_t            st;
    logic [5:0]         cnt;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         mode = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] element_value;
  logic [5:0]         element_count;
  logic               last;

  logic signed [31:0] shadow_list[$];
  beat_t              pending_beats[$];
  int                 errors = 0;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  bit                 calm = 1'b0;

  // typed rows carry one beat with found, element_value zero and last set
  row_t dir_tbl [22] = '{
    '{MODE_DUMP_FWD,   32'sd0,          1'b1, STAT_EMPTY, 6'd0},
    '{MODE_DUMP_BWD,   -32'sd1,         1'b1, STAT_EMPTY, 6'd0},
    '{MODE_SEARCH,     32'sd0,          1'b1, STAT_EMPTY, 6'd0},
    '{MODE_DELETE,     32'sd0,          1'b1, STAT_EMPTY, 6'd0},
    '{MODE_COUNT,      32'sd5,          1'b1, STAT_OK,    6'd0},
    '{MODE_PUSH_BACK,  32'sh7fffffff,   1'b1, STAT_OK,    6'd1},
    '{MODE_PUSH_FRONT, 32'sh80000000,   1'b1, STAT_OK,    6'd2},
    '{MODE_PUSH_BACK,  -32'sd1,         1'b0, STAT_OK,    6'd0},
    '{MODE_PUSH_FRONT, 32'sd0,          1'b0, STAT_OK,    6'd0},
    '{MODE_PUSH_BACK,  32'sh7fffffff,   1'b0, STAT_OK,    6'd0},
    '{MODE_SEARCH,     32'sh7fffffff,   1'b0, STAT_OK,    6'd0},
    '{MODE_SEARCH,     32'sh12345678,   1'b0, STAT_OK,    6'd0},
    '{MODE_DUMP_FWD,   32'sd0,          1'b0, STAT_OK,    6'd0},
    '{MODE_DUMP_BWD,   32'sd0,          1'b0, STAT_OK,    6'd0},
    '{MODE_DELETE,     32'sh7fffffff,   1'b0, STAT_OK,    6'd0},
    '{MODE_DELETE,     32'sd0,          1'b0, STAT_OK,    6'd0},
    '{MODE_DELETE,     32'sh7fffffff,   1'b0, STAT_OK,    6'd0},
    '{MODE_DELETE,     32'sh55555555,   1'b0, STAT_OK,    6'd0},
    '{MODE_COUNT,      32'shaaaaaaaa,   1'b0, STAT_OK,    6'd0},
    '{MODE_DUMP_FWD,   32'sd0,          1'b0, STAT_OK,    6'd0},
    '{MODE_CLEAR,      -32'sd1,         1'b1, STAT_OK,    6'd0},
    '{MODE_DUMP_BWD,   32'sd0,          1'b1, STAT_EMPTY, 6'd0}
  };

  bounded_deque_search_delete_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found        (found),
    .element_value(element_value),
    .element_count(element_count),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // applies one item to the shadow list and queues the beats it causes
  task automatic compute_deque_beats(input mode_t m, input logic signed [31:0] v);
    beat_t b;
    int    i;
    int    hit;
    b   = '{status: STAT_OK, found: 1'b0, elem: '0, cnt: '0, last: 1'b1};
    hit = -1;
    for (i = 0; i < shadow_list.size(); i++)
      if (hit < 0 && shadow_list[i] == v) hit = i;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_list.size() >= CAP) b.status = STAT_FULL;
        else if (m == MODE_PUSH_FRONT) shadow_list.push_front(v);
        else shadow_list.push_back(v);
      end
      MODE_DUMP_FWD, MODE_DUMP_BWD: begin
        if (shadow_list.size() == 0) begin
          b.status = STAT_EMPTY;
        end else begin
          for (i = 0; i < shadow_list.size(); i++) begin
            b.elem = (m == MODE_DUMP_FWD) ? shadow_list[i]
                                          : shadow_list[shadow_list.size() - 1 - i];
            b.cnt  = 6'(shadow_list.size());
            b.last = (i == shadow_list.size() - 1);
            pending_beats.push_back(b);
          end
          return;
        end
      end
      MODE_SEARCH: begin
        if (shadow_list.size() == 0) b.status = STAT_EMPTY;
        else if (hit >= 0) b.found = 1'b1;
        else b.status = STAT_NOT_FOUND;
      end
      MODE_DELETE: begin
        if (shadow_list.size() == 0) b.status = STAT_EMPTY;
        else if (hit >= 0) shadow_list.delete(hit);
        else b.status = STAT_NOT_FOUND;
      end
      MODE_CLEAR: shadow_list.delete();
      default: ;
    endcase
    b.cnt = 6'(shadow_list.size());
    pending_beats.push_back(b);
  endtask

  task automatic send_item(input mode_t m, input logic signed [31:0] v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    do @(posedge clk); while (in_stall);
    compute_deque_beats(m, v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  // favors values already held so that search and delete hit
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r < 75) return int'($urandom_range(0, 8)) - 4;
    if (r < 82) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  initial begin : stimulus
    int    i;
    int    r;
    int    phase;
    mode_t m;
    phase = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(dir_tbl); i++) begin
      send_item(dir_tbl[i].m, dir_tbl[i].v);
      if (dir_tbl[i].typed)
        pending_beats[pending_beats.size() - 1] =
          '{status: dir_tbl[i].st, found: 1'b0, elem: '0, cnt: dir_tbl[i].cnt, last: 1'b1};
    end
    wait_drained();

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 40 == 0) begin
        phase     = (i == 0) ? 0 : $urandom_range(0, 2);
        gap_pct   = 20 * $urandom_range(0, 2);
        stall_pct = 20 * $urandom_range(0, 2);
      end
      if (i == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (i % 64 == 63) wait_drained();
      r = $urandom_range(0, 99);
      case (phase)
        0: begin
          if (r < 85) m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
          else if (r < 93) m = $urandom_range(0, 1) ? MODE_DUMP_FWD : MODE_DUMP_BWD;
          else m = $urandom_range(0, 1) ? MODE_SEARCH : MODE_COUNT;
        end
        1: begin
          if (r < 65) m = MODE_DELETE;
          else if (r < 80) m = MODE_SEARCH;
          else if (r < 90) m = $urandom_range(0, 1) ? MODE_DUMP_FWD : MODE_DUMP_BWD;
          else m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
        end
        default: begin
          if (r < 3) m = MODE_CLEAR;
          else m = mode_t'($urandom_range(0, 6));
        end
      endcase
      send_item(m, pick_value());
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0)
      $display("** bounded_deque_search_delete_top: PASSED **");
    else
      $display("** bounded_deque_search_delete_top: FAILED **");
    $finish;
  end

  initial begin : back_pressure
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst || calm) begin
        out_stall <= 1'b0;
      end else if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < stall_pct) hold = $urandom_range(1, 9);
      end
    end
  end

  always @(posedge clk) begin : beat_check
    beat_t got;
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{status: status_t'(status), found: found, elem: element_value,
              cnt: element_count, last: last};
      if (pending_beats.size() == 0) begin
        if (errors < 10)
          $display("unexpected beat: status=%0d found=%0d elem=%0d count=%0d last=%0d",
                   got.status, got.found, got.elem, got.cnt, got.last);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.elem !== want.elem || got.cnt !== want.cnt || got.last !== want.last) begin
          if (errors < 10)
            $display({"beat mismatch: got status=%0d found=%0d elem=%0d count=%0d last=%0d",
                      " / want status=%0d found=%0d elem=%0d count=%0d last=%0d"},
                     got.status, got.found, got.elem, got.cnt, got.last,
                     want.status, want.found, want.elem, want.cnt, want.last);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("** bounded_deque_search_delete_top: FAILED **");
    $finish;
  end

endmodule
